/* hw/rtl/sof_frame_encoder_xor_checksum_top_assert.svh */
// assertion macros used by the frame encoder queue module
`ifndef SOF_FRAME_ENCODER_XOR_CHECKSUM_TOP_ASSERT_SVH
`define SOF_FRAME_ENCODER_XOR_CHECKSUM_TOP_ASSERT_SVH

// property checked on every clock edge outside reset
`define SOFX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define SOFX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/sofx_pkg.sv */
package sofx_pkg;

  // start of frame marker
  localparam logic [7:0] SofByte = 8'hFE;

  // input opcodes
  localparam logic OpStart   = 1'b0;
  localparam logic OpPayload = 1'b1;

  // last step of each command in the back end
  localparam logic [2:0] StepHdrLast  = 3'd4;
  localparam logic [2:0] StepHdrCsum  = 3'd5;
  localparam logic [2:0] StepPldLast  = 3'd0;
  localparam logic [2:0] StepPldCsum  = 3'd1;

  typedef struct packed {
    logic        opcode;
    logic [15:0] function_code;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_item_t;

  typedef enum logic {
    CMD_HEADER,
    CMD_PAYLOAD
  } cmd_kind_e;

  // classified work handed from front to back
  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] function_code;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic        close;
    logic [7:0]  checksum;
  } cmd_t;

endpackage

/* hw/rtl/sofx_front.sv */
module sofx_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sofx_pkg::in_item_t in_data_i,
  input  logic              full_i,
  output logic              push_o,
  output sofx_pkg::cmd_t    push_data_o
);
  import sofx_pkg::*;

  logic [7:0]  running_xor_q, running_xor_d;
  logic [15:0] bytes_remaining_q, bytes_remaining_d;
  logic        frame_open_q, frame_open_d;

  logic        accept;
  logic [7:0]  hdr_csum;
  logic [7:0]  pld_csum;
  logic [15:0] rem_next;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign hdr_csum = SofByte ^ in_data_i.function_code[15:8] ^ in_data_i.function_code[7:0];
  assign pld_csum = running_xor_q ^ in_data_i.payload_byte;
  assign rem_next = bytes_remaining_q - 16'd1;

  // classify the transaction and update frame state
  always_comb begin
    running_xor_d     = running_xor_q;
    bytes_remaining_d = bytes_remaining_q;
    frame_open_d      = frame_open_q;
    push_o            = 1'b0;
    push_data_o       = '0;
    push_data_o.function_code  = in_data_i.function_code;
    push_data_o.payload_length = in_data_i.payload_length;
    push_data_o.payload_byte   = in_data_i.payload_byte;
    if (accept) begin
      if (in_data_i.opcode == OpStart) begin
        push_o                 = 1'b1;
        push_data_o.kind       = CMD_HEADER;
        push_data_o.close      = (in_data_i.payload_length == 16'd0);
        push_data_o.checksum   = hdr_csum;
        running_xor_d          = hdr_csum;
        bytes_remaining_d      = in_data_i.payload_length;
        frame_open_d           = (in_data_i.payload_length != 16'd0);
      end else if (frame_open_q) begin
        push_o                 = 1'b1;
        push_data_o.kind       = CMD_PAYLOAD;
        push_data_o.close      = (rem_next == 16'd0);
        push_data_o.checksum   = pld_csum;
        running_xor_d          = pld_csum;
        bytes_remaining_d      = rem_next;
        frame_open_d           = (rem_next != 16'd0);
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_xor_q     <= '0;
      bytes_remaining_q <= '0;
      frame_open_q      <= 1'b0;
    end else begin
      running_xor_q     <= running_xor_d;
      bytes_remaining_q <= bytes_remaining_d;
      frame_open_q      <= frame_open_d;
    end
  end

endmodule

/* hw/rtl/sofx_queue.sv */
`include "sof_frame_encoder_xor_checksum_top_assert.svh"

module sofx_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sofx_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output sofx_pkg::cmd_t head_data_o
);
  import sofx_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = entries_q[rd_ptr_q];

  // storage write
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // queue checks
  `SOFX_ASSERT(a_no_push_full, push_i |-> !full_o, "push into full queue")
  `SOFX_ASSERT(a_no_pop_empty, pop_i |-> head_valid_o, "pop from empty queue")
  `SOFX_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue count out of range")
  `SOFX_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (count_q == '0), "queue not empty after reset")

endmodule

/* hw/rtl/sofx_back.sv */
module sofx_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  sofx_pkg::cmd_t      head_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sofx_pkg::out_item_t out_data_o
);
  import sofx_pkg::*;

  logic [2:0] step_q;
  logic       out_valid_q;
  out_item_t  out_q;

  logic       load;
  logic       last_step;
  out_item_t  next_item;

  assign load = head_valid_i && (!out_valid_q || out_ready_i);

  // select the byte for the current step of the head command
  always_comb begin
    next_item = '0;
    last_step = 1'b0;
    unique case (head_data_i.kind)
      CMD_HEADER: begin
        last_step = head_data_i.close ? (step_q == StepHdrCsum) : (step_q == StepHdrLast);
        case (step_q)
          3'd0:    next_item.out_byte = SofByte;
          3'd1:    next_item.out_byte = head_data_i.function_code[15:8];
          3'd2:    next_item.out_byte = head_data_i.function_code[7:0];
          3'd3:    next_item.out_byte = head_data_i.payload_length[15:8];
          3'd4:    next_item.out_byte = head_data_i.payload_length[7:0];
          default: begin
            next_item.out_byte  = head_data_i.checksum;
            next_item.frame_end = 1'b1;
          end
        endcase
      end
      CMD_PAYLOAD: begin
        last_step = head_data_i.close ? (step_q == StepPldCsum) : (step_q == StepPldLast);
        if (step_q == StepPldLast) begin
          next_item.out_byte = head_data_i.payload_byte;
        end else begin
          next_item.out_byte  = head_data_i.checksum;
          next_item.frame_end = 1'b1;
        end
      end
      default: begin
        last_step = 1'b1;
      end
    endcase
  end

  assign pop_o = load && last_step;

  // step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q      <= last_step ? 3'd0 : step_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output data register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= next_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/sof_frame_encoder_xor_checksum_top.sv */
// Serial frame encoder with XOR checksum. A start transaction (opcode 0) emits the
// bytes FE, function code high and low, payload length high and low, and, when the
// length is zero, the checksum with frame_end set. Each payload transaction (opcode 1)
// inside an open frame emits its byte, followed by the checksum after the last one;
// payload with no open frame is dropped and a new start abandons an open frame. The
// checksum is the XOR of FE, both function-code bytes and all payload bytes. The
// front end takes one input transaction per cycle while the command queue
// (QueueDepth entries) has room; the back end emits one byte per cycle from its
// output register while out_ready_i is high, so a start item yields 5 or 6 bytes
// and a payload item 1 or 2. Sustained throughput is one output byte per cycle.
module sof_frame_encoder_xor_checksum_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sofx_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sofx_pkg::out_item_t out_data_o
);
  import sofx_pkg::*;

  logic full;
  logic push;
  cmd_t push_data;
  logic pop;
  logic head_valid;
  cmd_t head_data;

  // classify input transactions and track frame state
  sofx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // command queue between front and back
  sofx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  // expand commands into the byte stream
  sofx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
